// ===== rtl/tccb_pkg.sv =====
package tccb_pkg;

	// screen geometry
	localparam int ROWS = 4;
	localparam int COLS = 21;
	localparam int CELLS = ROWS * COLS;

	// internal widths that follow from the geometry
	localparam int ROW_W = $clog2(ROWS);
	localparam int ROWP_W = ROW_W + 1;
	localparam int COL_W = $clog2(COLS);
	localparam int ADDR_W = $clog2(CELLS);

	// fixed field widths of the stream items
	localparam int CHAR_W = 8;
	localparam int ROW_FW = 2;
	localparam int COL_FW = 5;
	localparam int ACT_W = 2;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 16;

	// depth of the command queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// special characters
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	// action codes on the input stream
	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	// classified commands for the back part
	typedef enum logic [2:0] {
		CMD_PUT = 3'd0,
		CMD_NEWLINE = 3'd1,
		CMD_READ = 3'd2,
		CMD_CLEAR = 3'd3,
		CMD_NOP = 3'd4
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic [CHAR_W-1:0] ch;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} cmd_t;

	// physical row of a logical row in the ring of rows
	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
			input logic [ROW_W-1:0] line);
		logic [ROWP_W-1:0] s;
		s = {1'b0, top} + {1'b0, line};
		if (s >= ROWP_W'(ROWS)) begin
			s = s - ROWP_W'(ROWS);
		end
		return s[ROW_W-1:0];
	endfunction

	// linear cell address of a physical row and column
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
			input logic [COL_W-1:0] col);
		return ADDR_W'(ADDR_W'(prow) * ADDR_W'(COLS)) + ADDR_W'(col);
	endfunction

endpackage

// ===== rtl/text_console_char_buffer.sv =====
// Character buffer of a text console: ROWS x COLS bytes with a linear cursor.
// Each input item (write, read, clear or unused) gives exactly one result item
// with the cell character (reads only, else zero) and the cursor after the
// item. A front stage classifies items into a two-entry command queue, so
// input is taken while a result waits. The back executes one command at a
// time; a read passes through a second state, as the store has a registered
// read port. The next command starts once the previous result has been taken.
// A newline blanks the rest of the line at once through per-cell written
// flags, and scrolling rotates a top-row pointer instead of moving data.
// Reset empties all flags at once, so the store is ready right after reset
// with no clearing pass.
module text_console_char_buffer
	import tccb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // char_code[7:0], row[9:8], col[14:10]
	input  logic [ACT_W-1:0]      s_tuser,  // action[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // cell_char[7:0], cursor_row[9:8], cur_col[14:10]
);

	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	logic cmd_valid;
	cmd_t head;

	tccb_front u_front (
		.tvalid(s_tvalid),
		.tready(s_tready),
		.tuser(s_tuser),
		.tdata(s_tdata),
		.full(full),
		.push(push),
		.push_cmd(push_cmd)
	);

	tccb_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(full),
		.pop(pop),
		.valid(cmd_valid),
		.head(head)
	);

	tccb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(head),
		.pop(pop),
		.tvalid(m_tvalid),
		.tready(m_tready),
		.tdata(m_tdata)
	);

endmodule

// ===== rtl/tccb_ram.sv =====
module tccb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 84
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/tccb_front.sv =====
module tccb_front
	import tccb_pkg::*;
(
	input  logic                 tvalid,
	output logic                 tready,
	input  logic [ACT_W-1:0]     tuser,
	input  logic [IN_DATA_W-1:0] tdata,
	input  logic                 full,
	output logic                 push,
	output cmd_t                 push_cmd
);

	logic [CHAR_W-1:0] ch;
	logic [ROW_FW-1:0] rd_row;
	logic [COL_FW-1:0] rd_col;
	logic in_range;

	assign ch = tdata[CHAR_W-1:0];
	assign rd_row = tdata[CHAR_W +: ROW_FW];
	assign rd_col = tdata[CHAR_W+ROW_FW +: COL_FW];
	assign in_range = (int'(rd_row) < ROWS) && (int'(rd_col) < COLS);

	// take an item whenever the queue has room
	assign tready = !full;
	assign push = tvalid && !full;

	// classify the item into a command
	always_comb begin
		push_cmd.ch = ch;
		push_cmd.row = ROW_W'(rd_row);
		push_cmd.col = COL_W'(rd_col);
		case (action_t'(tuser))
			ACT_WRITE: push_cmd.op = (ch == CH_NEWLINE) ? CMD_NEWLINE : CMD_PUT;
			ACT_READ: push_cmd.op = in_range ? CMD_READ : CMD_NOP;
			ACT_CLEAR: push_cmd.op = CMD_CLEAR;
			default: push_cmd.op = CMD_NOP;
		endcase
	end

endmodule

// ===== rtl/tccb_fifo.sv =====
module tccb_fifo
	import tccb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t head
);

	cmd_t entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign valid = (count_q != '0);
	assign head = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/tccb_back.sv =====
module tccb_back
	import tccb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  cmd_t                  cmd,
	output logic                  pop,
	output logic                  tvalid,
	input  logic                  tready,
	output logic [OUT_DATA_W-1:0] tdata
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t state_q;
	logic [ROW_W-1:0] cursor_line_q;
	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] top_q;
	logic [CELLS-1:0] valid_q;
	logic rd_valid_q;
	logic out_valid_q;
	logic [CHAR_W-1:0] out_char_q;

	logic [ROW_W-1:0] cur_prow;
	logic [ROW_W-1:0] rd_prow;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [CHAR_W-1:0] rdata;
	logic do_put;
	logic do_nl;
	logic do_adv;
	logic wrap;
	logic scroll;
	logic [ROW_W-1:0] next_line;
	logic [COL_W-1:0] next_col;
	logic [ROW_W-1:0] next_top;

	// take a command only when the result register is free
	assign pop = (state_q == ST_IDLE) && cmd_valid && !out_valid_q;
	assign do_put = pop && (cmd.op == CMD_PUT);
	assign do_nl = pop && (cmd.op == CMD_NEWLINE);
	assign do_adv = do_put || do_nl;

	// addresses in the ring of rows
	assign cur_prow = phys_row(top_q, cursor_line_q);
	assign rd_prow = phys_row(top_q, cmd.row);
	assign waddr = cell_addr(cur_prow, cur_col_q);
	assign raddr = cell_addr(rd_prow, cmd.col);

	// cursor advance, wrap and scroll
	always_comb begin
		wrap = (cmd.op == CMD_NEWLINE) || (cur_col_q == COL_W'(COLS - 1));
		scroll = wrap && (cursor_line_q == ROW_W'(ROWS - 1));
		next_top = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + 1'b1;
		next_line = cursor_line_q;
		next_col = cur_col_q + 1'b1;
		if (wrap) begin
			next_col = '0;
			if (!scroll) begin
				next_line = cursor_line_q + 1'b1;
			end
		end
	end

	tccb_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(CELLS)
	) u_store (
		.clk(clk),
		.we(do_put),
		.waddr(waddr),
		.wdata(cmd.ch),
		.raddr(raddr),
		.rdata(rdata)
	);

	// per-cell written flags: a cell without one reads as a space
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (pop && (cmd.op == CMD_CLEAR)) begin
			valid_q <= '0;
		end else begin
			if (do_put) begin
				valid_q[waddr] <= 1'b1;
			end
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < COLS; c++) begin
					if ((do_nl && (ROW_W'(r) == cur_prow) && (COL_W'(c) >= cur_col_q)) ||
							(do_adv && scroll && (ROW_W'(r) == top_q))) begin
						valid_q[r*COLS + c] <= 1'b0;
					end
				end
			end
		end
	end

	// cursor, ring top and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cursor_line_q <= '0;
			cur_col_q <= '0;
			top_q <= '0;
			out_valid_q <= 1'b0;
			rd_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (cmd.op)
							CMD_PUT, CMD_NEWLINE: begin
								cursor_line_q <= next_line;
								cur_col_q <= next_col;
								if (scroll) begin
									top_q <= next_top;
								end
								out_valid_q <= 1'b1;
							end
							CMD_READ: begin
								rd_valid_q <= valid_q[raddr];
								state_q <= ST_READ;
							end
							CMD_CLEAR: begin
								cursor_line_q <= '0;
								cur_col_q <= '0;
								top_q <= '0;
								out_valid_q <= 1'b1;
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_READ: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// character part of the result
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			out_char_q <= rd_valid_q ? rdata : CH_SPACE;
		end else if (pop) begin
			out_char_q <= '0;
		end
	end

	assign tvalid = out_valid_q;
	assign tdata = {{(OUT_DATA_W - CHAR_W - ROW_FW - COL_FW){1'b0}},
		COL_FW'(cur_col_q), ROW_FW'(cursor_line_q), out_char_q};

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import tccb_pkg::*;

	// result item fields
	typedef struct packed {
		logic [CHAR_W-1:0] glyph;
		logic [ROW_FW-1:0] crow;
		logic [COL_FW-1:0] ccol;
	} console_result_t;

	// one row of the directed table, with an optional typed-in result
	typedef struct packed {
		action_t           act;
		logic [CHAR_W-1:0] ch;
		logic [ROW_FW-1:0] r;
		logic [COL_FW-1:0] c;
		bit                typed;
		console_result_t   want;
	} console_row_t;

	localparam int DIR_ROWS = 22;
	localparam int RAND_PER_PHASE = 276;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;  // char_code[7:0], row[9:8], col[14:10]
	logic [ACT_W-1:0]      s_tuser = '0;  // action[1:0]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;       // cell_char[7:0], cursor_row[9:8], cur_col[14:10]

	// shadow of the screen and cursor
	logic [CHAR_W-1:0] screen_shadow [ROWS][COLS];
	int                shadow_line;
	int                shadow_column;

	console_result_t awaited_results [$];
	console_result_t got_result;
	console_result_t oldest_result;

	int failures = 0;
	int sender_gap_pct = 0;
	int receiver_gap_pct = 0;
	int receiver_hold_cycles = 0;

	// coverage tallies
	int n_items = 0;
	int n_puts = 0;
	int n_newlines = 0;
	int n_reads = 0;
	int n_outside = 0;
	int n_clears = 0;
	int n_unused = 0;
	int n_scrolls = 0;
	int n_results = 0;

	console_row_t directed_rows [DIR_ROWS] = '{
		// fresh screen reads, both corners and outside columns
		'{ACT_READ,  8'h00, 2'd0, 5'd0,  1'b1, '{8'h20, 2'd0, 5'd0}},
		'{ACT_READ,  8'hff, 2'd3, 5'd20, 1'b1, '{8'h20, 2'd0, 5'd0}},
		'{ACT_READ,  8'h00, 2'd0, 5'd21, 1'b1, '{8'h00, 2'd0, 5'd0}},
		'{ACT_READ,  8'hff, 2'd3, 5'd31, 1'b1, '{8'h00, 2'd0, 5'd0}},
		// unused action with every other field set
		'{ACT_NONE,  8'hff, 2'd3, 5'd31, 1'b1, '{8'h00, 2'd0, 5'd0}},
		// character extremes
		'{ACT_WRITE, 8'h41, 2'd3, 5'd31, 1'b1, '{8'h00, 2'd0, 5'd1}},
		'{ACT_WRITE, 8'h00, 2'd0, 5'd0,  1'b1, '{8'h00, 2'd0, 5'd2}},
		'{ACT_WRITE, 8'hff, 2'd2, 5'd9,  1'b1, '{8'h00, 2'd0, 5'd3}},
		'{ACT_READ,  8'h0a, 2'd0, 5'd0,  1'b1, '{8'h41, 2'd0, 5'd3}},
		'{ACT_READ,  8'h00, 2'd0, 5'd2,  1'b1, '{8'hff, 2'd0, 5'd3}},
		// newline mid-line, then newline at column zero
		'{ACT_WRITE, 8'h0a, 2'd1, 5'd1,  1'b1, '{8'h00, 2'd1, 5'd0}},
		'{ACT_WRITE, 8'h0a, 2'd0, 5'd0,  1'b1, '{8'h00, 2'd2, 5'd0}},
		'{ACT_WRITE, 8'h0b, 2'd3, 5'd17, 1'b0, '0},
		'{ACT_WRITE, 8'h0a, 2'd0, 5'd0,  1'b0, '0},
		'{ACT_WRITE, 8'h5a, 2'd0, 5'd0,  1'b0, '0},
		// newline on the bottom row scrolls
		'{ACT_WRITE, 8'h0a, 2'd0, 5'd0,  1'b0, '0},
		'{ACT_READ,  8'h00, 2'd0, 5'd0,  1'b0, '0},
		'{ACT_READ,  8'h00, 2'd2, 5'd0,  1'b0, '0},
		'{ACT_WRITE, 8'h0a, 2'd0, 5'd0,  1'b0, '0},
		// clear ignores its character, then reads on the blank screen
		'{ACT_CLEAR, 8'h0a, 2'd3, 5'd31, 1'b1, '{8'h00, 2'd0, 5'd0}},
		'{ACT_READ,  8'h00, 2'd2, 5'd0,  1'b1, '{8'h20, 2'd0, 5'd0}},
		'{ACT_READ,  8'h0a, 2'd1, 5'd5,  1'b1, '{8'h20, 2'd0, 5'd0}}
	};

	text_console_char_buffer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// blank screen, cursor home
	function automatic void clear_shadow();
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				screen_shadow[r][c] = CH_SPACE;
			end
		end
		shadow_line = 0;
		shadow_column = 0;
	endfunction

	// store one cell at the cursor, wrap and scroll
	function automatic void put_shadow_cell(input logic [CHAR_W-1:0] ch);
		screen_shadow[shadow_line][shadow_column] = ch;
		shadow_column++;
		if (shadow_column >= COLS) begin
			shadow_column = 0;
			shadow_line++;
			if (shadow_line >= ROWS) begin
				for (int r = 0; r < ROWS - 1; r++) begin
					screen_shadow[r] = screen_shadow[r + 1];
				end
				for (int c = 0; c < COLS; c++) begin
					screen_shadow[ROWS - 1][c] = CH_SPACE;
				end
				shadow_line = ROWS - 1;
				n_scrolls++;
			end
		end
	endfunction

	// next result of the console for one item
	function automatic console_result_t console_step(input action_t act,
			input logic [CHAR_W-1:0] ch, input logic [ROW_FW-1:0] r,
			input logic [COL_FW-1:0] c);
		console_result_t res;
		int blanks;
		res = '0;
		n_items++;
		case (act)
			ACT_WRITE: begin
				if (ch == CH_NEWLINE) begin
					blanks = COLS - shadow_column;
					for (int i = 0; i < blanks; i++) begin
						put_shadow_cell(CH_SPACE);
					end
					n_newlines++;
				end else begin
					put_shadow_cell(ch);
					n_puts++;
				end
			end
			ACT_READ: begin
				n_reads++;
				if (int'(r) < ROWS && int'(c) < COLS) begin
					res.glyph = screen_shadow[r][c];
				end else begin
					n_outside++;
				end
			end
			ACT_CLEAR: begin
				clear_shadow();
				n_clears++;
			end
			default: begin
				n_unused++;
			end
		endcase
		res.crow = ROW_FW'(shadow_line);
		res.ccol = COL_FW'(shadow_column);
		return res;
	endfunction

	// offer one item; entered and left at a falling edge
	task automatic send_item(input action_t act, input logic [CHAR_W-1:0] ch,
			input logic [ROW_FW-1:0] r, input logic [COL_FW-1:0] c,
			input bit typed, input console_result_t typed_res);
		console_result_t res;
		while ($urandom_range(99) < sender_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, c, r, ch};
		s_tuser <= act;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		res = console_step(act, ch, r, c);
		awaited_results.push_back(typed ? typed_res : res);
		@(negedge clk);
	endtask

	// random item, mostly text with newlines, a fair share of reads
	task automatic send_random_item();
		int unsigned pick;
		action_t act;
		logic [CHAR_W-1:0] ch;
		logic [COL_FW-1:0] c;
		pick = $urandom_range(99);
		if (pick < 1) begin
			act = ACT_CLEAR;
		end else if (pick < 4) begin
			act = ACT_NONE;
		end else if (pick < 28) begin
			act = ACT_READ;
		end else begin
			act = ACT_WRITE;
		end
		ch = ($urandom_range(99) < 12) ? CH_NEWLINE : CHAR_W'($urandom_range(255));
		c = ($urandom_range(99) < 85) ? COL_FW'($urandom_range(COLS - 1))
			: COL_FW'($urandom_range(31, COLS));
		send_item(act, ch, ROW_FW'($urandom_range(3)), c, 1'b0, '0);
	endtask

	// hold the input back until every result has come
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (awaited_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// receiver: random gaps, plus a long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (receiver_hold_cycles > 0) begin
				m_tready <= 1'b0;
				receiver_hold_cycles--;
			end else begin
				m_tready <= ($urandom_range(99) >= receiver_gap_pct);
			end
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_result = {m_tdata[CHAR_W-1:0], m_tdata[CHAR_W +: ROW_FW],
				m_tdata[CHAR_W+ROW_FW +: COL_FW]};
			n_results++;
			if (awaited_results.size() == 0) begin
				$error("result item with nothing awaited: tdata %h", m_tdata);
				failures++;
			end else begin
				oldest_result = awaited_results.pop_front();
				if (got_result.glyph !== oldest_result.glyph) begin
					$error("cell_char: expected %h, actual %h",
						oldest_result.glyph, got_result.glyph);
					failures++;
				end
				if (got_result.crow !== oldest_result.crow) begin
					$error("cursor_row: expected %0d, actual %0d",
						oldest_result.crow, got_result.crow);
					failures++;
				end
				if (got_result.ccol !== oldest_result.ccol) begin
					$error("cur_col: expected %0d, actual %0d",
						oldest_result.ccol, got_result.ccol);
					failures++;
				end
			end
		end
	end

	// main sequence
	initial begin
		clear_shadow();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].act, directed_rows[i].ch, directed_rows[i].r,
				directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);
		end
		drain_results();

		// random phases: slow receiver, then slow sender, then full rate after a receiver hold-off
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_gap_pct = 26;
					receiver_gap_pct = 79;
				end
				1: begin
					sender_gap_pct = 79;
					receiver_gap_pct = 26;
				end
				default: begin
					sender_gap_pct = 0;
					receiver_gap_pct = 0;
					receiver_hold_cycles = 250;
				end
			endcase
			repeat (RAND_PER_PHASE) send_random_item();
			drain_results();
		end

		repeat (20) @(posedge clk);
		$display("covered %0d items / %0d results: %0d chars, %0d newlines, %0d scrolls",
			n_items, n_results, n_puts, n_newlines, n_scrolls);
		$display("  %0d reads (%0d outside the screen), %0d clears, %0d unused actions",
			n_reads, n_outside, n_clears, n_unused);
		if (failures == 0 && awaited_results.size() == 0) begin
			$display("** text_console_char_buffer: PASSED **");
		end else begin
			$display("** text_console_char_buffer: FAILED **");
		end
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("timeout with %0d results still awaited", awaited_results.size());
		$display("** text_console_char_buffer: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tccb_pkg.sv
rtl/tccb_ram.sv
rtl/tccb_front.sv
rtl/tccb_fifo.sv
rtl/tccb_back.sv
rtl/text_console_char_buffer.sv
dv/tb_top.sv
